FILE: rtl/core/fmacl_pkg.sv
// Package: shared types and constants of the first-match packet ACL.
`timescale 1ns / 1ps

package fmacl_pkg;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic MODE_WRITE    = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    localparam logic KIND_ACK      = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    localparam int CFG_W   = 5;
    localparam int COUNT_W = 5;
    localparam int HIT_W   = 4;
    localparam int GROUP_LANES = 16;

    localparam logic REG_RULE_COUNT     = 1'b0;
    localparam logic REG_DEFAULT_POLICY = 1'b1;

    typedef struct packed {
        logic [31:0] src_prefix;
        logic [31:0] src_mask;
        logic [31:0] dst_prefix;
        logic [31:0] dst_mask;
        logic [7:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        action;
    } rule_t;

    typedef struct packed {
        logic        is_ipv4;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  ip_protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } pkt_key_t;

endpackage

FILE: rtl/core/fmacl_if.sv
// Interfaces: request and result channels of the packet ACL.
`timescale 1ns / 1ps

interface fmacl_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [3:0]  rule_index;
    logic        is_ipv4;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] src_mask;
    logic [31:0] dst_mask;
    logic [7:0]  ip_protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        rule_verdict;

    modport source (
        output valid, mode, rule_index, is_ipv4, src_addr, dst_addr, src_mask, dst_mask,
               ip_protocol, src_port, dst_port, rule_verdict,
        input  ready
    );
    modport sink (
        input  valid, mode, rule_index, is_ipv4, src_addr, dst_addr, src_mask, dst_mask,
               ip_protocol, src_port, dst_port, rule_verdict,
        output ready
    );
endinterface

interface fmacl_rsp_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic       matched;
    logic       verdict;
    logic [3:0] hit_index;

    modport source (
        output valid, result_kind, matched, verdict, hit_index,
        input  ready
    );
    modport sink (
        input  valid, result_kind, matched, verdict, hit_index,
        output ready
    );
endinterface

FILE: rtl/core/first_match_packet_acl.sv
// Top level: first-match five-tuple IPv4 ACL classifier pipeline.
//
//  port      | dir | contents
//  req       | in  | rule write or packet header beat
//  rsp       | out | write ack or classification beat
//  cfg_*     | in  | rule_count (index 0), default_policy (index 1)
//
// One beat accepted per cycle while req.ready is high; each passes every stage in order.
// Stages: input register, parallel rule match, per-16-slot first hit, output register.
// A rule write lands in the table as its beat is accepted and is seen by every later packet.
// A rsp stall holds full stages up to a bubble; req.ready falls if the input stage is held.
// Reset clears valid bits and config registers; rule contents stay undefined until written.
`timescale 1ns / 1ps

module first_match_packet_acl #(
    parameter int RULE_SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fmacl_req_if.sink                   req,
    fmacl_rsp_if.source                 rsp,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [fmacl_pkg::CFG_W-1:0] cfg_data
);
    import fmacl_pkg::*;

    localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int GROUPS = (RULE_SLOTS + GROUP_LANES - 1) / GROUP_LANES;
    localparam int LANES  = GROUPS * GROUP_LANES;

    logic [COUNT_W-1:0] rule_count_reg;
    logic               default_policy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg     <= '0;
            default_policy_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RULE_COUNT:     rule_count_reg     <= cfg_data[COUNT_W-1:0];
                REG_DEFAULT_POLICY: default_policy_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    logic en1, en2, en3, en4;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    assign en4 = !s4_valid_reg || rsp.ready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign req.ready = en1;

    logic       in_accept;
    logic [8:0] wr_slot_wide;
    logic       wr_en;
    rule_t      wr_rule;

    assign in_accept    = req.valid && req.ready;
    assign wr_slot_wide = {5'b0, req.rule_index};
    assign wr_en        = in_accept && (req.mode == MODE_WRITE)
                       && (wr_slot_wide < 9'(RULE_SLOTS));

    assign wr_rule.src_prefix = req.src_addr;
    assign wr_rule.src_mask   = req.src_mask;
    assign wr_rule.dst_prefix = req.dst_addr;
    assign wr_rule.dst_mask   = req.dst_mask;
    assign wr_rule.protocol   = req.ip_protocol;
    assign wr_rule.src_port   = req.src_port;
    assign wr_rule.dst_port   = req.dst_port;
    assign wr_rule.action     = req.rule_verdict;

    logic     s1_mode_reg;
    pkt_key_t s1_key_reg;

    logic             s2_mode_reg;
    logic [LANES-1:0] s2_hits_reg;
    logic [LANES-1:0] s2_act_reg;
    logic [LANES-1:0] hits_next;
    logic [LANES-1:0] act_next;

    logic                        s3_mode_reg;
    logic [GROUPS-1:0]           s3_found_reg;
    logic [GROUPS-1:0][HIT_W-1:0] s3_off_reg;
    logic [GROUPS-1:0]           s3_act_reg;
    logic [GROUPS-1:0]           found_next;
    logic [GROUPS-1:0][HIT_W-1:0] off_next;
    logic [GROUPS-1:0]           act_grp_next;

    logic             s4_kind_reg;
    logic             s4_matched_reg;
    logic             s4_verdict_reg;
    logic [HIT_W-1:0] s4_hit_reg;
    logic             matched_next;
    logic             verdict_next;
    logic [HIT_W-1:0] hit_next;

    fmacl_rule_table #(
        .RULE_SLOTS (RULE_SLOTS),
        .SLOT_W     (SLOT_W),
        .LANES      (LANES)
    ) u_table (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_slot    (wr_slot_wide[SLOT_W-1:0]),
        .wr_rule    (wr_rule),
        .key        (s1_key_reg),
        .rule_count (rule_count_reg),
        .hits       (hits_next),
        .actions    (act_next)
    );

    always_comb
    begin
        found_next   = '0;
        off_next     = '0;
        act_grp_next = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            for (int j = GROUP_LANES - 1; j >= 0; j--)
            begin
                if (s2_hits_reg[g*GROUP_LANES + j])
                begin
                    found_next[g]   = 1'b1;
                    off_next[g]     = HIT_W'(j);
                    act_grp_next[g] = s2_act_reg[g*GROUP_LANES + j];
                end
            end
        end
    end

    always_comb
    begin
        matched_next = 1'b0;
        verdict_next = !default_policy_reg;
        hit_next     = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (s3_found_reg[g])
            begin
                matched_next = 1'b1;
                verdict_next = s3_act_reg[g];
                hit_next     = s3_off_reg[g];
            end
        end
        if (s3_mode_reg == MODE_WRITE)
        begin
            matched_next = 1'b0;
            verdict_next = 1'b0;
            hit_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= req.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_mode_reg            <= req.mode;
            s1_key_reg.is_ipv4     <= req.is_ipv4;
            s1_key_reg.src_addr    <= req.src_addr;
            s1_key_reg.dst_addr    <= req.dst_addr;
            s1_key_reg.ip_protocol <= req.ip_protocol;
            s1_key_reg.src_port    <= req.src_port;
            s1_key_reg.dst_port    <= req.dst_port;
        end
        if (en2)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_hits_reg <= (s1_mode_reg == MODE_CLASSIFY) ? hits_next : '0;
            s2_act_reg  <= act_next;
        end
        if (en3)
        begin
            s3_mode_reg  <= s2_mode_reg;
            s3_found_reg <= found_next;
            s3_off_reg   <= off_next;
            s3_act_reg   <= act_grp_next;
        end
        if (en4)
        begin
            s4_kind_reg    <= (s3_mode_reg == MODE_WRITE) ? KIND_ACK : KIND_CLASSIFY;
            s4_matched_reg <= matched_next;
            s4_verdict_reg <= verdict_next;
            s4_hit_reg     <= hit_next;
        end
    end

    assign rsp.valid       = s4_valid_reg;
    assign rsp.result_kind = s4_kind_reg;
    assign rsp.matched     = s4_matched_reg;
    assign rsp.verdict     = s4_verdict_reg;
    assign rsp.hit_index   = s4_hit_reg;

    a_ack_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.result_kind == KIND_ACK))
        |-> (!rsp.matched && !rsp.verdict && (rsp.hit_index == '0)))
        else $error("write ack carries non-zero result fields");

    a_unmatched_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.matched) |-> (rsp.hit_index == '0))
        else $error("unmatched result carries a hit index");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted beat lost at input stage");

    a_empty_s1_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> req.ready)
        else $error("input stalled with empty input stage");

endmodule

FILE: rtl/core/fmacl_rule_table.sv
// Rule table: rule storage and one parallel match lane per slot.
`timescale 1ns / 1ps

module fmacl_rule_table #(
    parameter int RULE_SLOTS = 16,
    parameter int SLOT_W     = 4,
    parameter int LANES      = 16
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [SLOT_W-1:0]            wr_slot,
    input  fmacl_pkg::rule_t             wr_rule,
    input  fmacl_pkg::pkt_key_t          key,
    input  logic [fmacl_pkg::COUNT_W-1:0] rule_count,
    output logic [LANES-1:0]             hits,
    output logic [LANES-1:0]             actions
);
    import fmacl_pkg::*;

    rule_t rules_reg [RULE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rules_reg[wr_slot] <= wr_rule;
        end
    end

    logic ports_used;
    assign ports_used = (key.ip_protocol == PROTO_TCP) || (key.ip_protocol == PROTO_UDP);

    always_comb
    begin
        hits    = '0;
        actions = '0;
        for (int k = 0; k < RULE_SLOTS; k++)
        begin
            logic lane_en;
            logic addr_ok;
            logic port_ok;
            lane_en = 9'(k) < {4'b0, rule_count};
            addr_ok = ((rules_reg[k].src_prefix & rules_reg[k].src_mask)
                       == (key.src_addr & rules_reg[k].src_mask))
                   && ((rules_reg[k].dst_prefix & rules_reg[k].dst_mask)
                       == (key.dst_addr & rules_reg[k].dst_mask))
                   && (rules_reg[k].protocol == key.ip_protocol);
            port_ok = !ports_used
                   || (((rules_reg[k].src_port == 16'd0)
                        || (rules_reg[k].src_port == key.src_port))
                    && ((rules_reg[k].dst_port == 16'd0)
                        || (rules_reg[k].dst_port == key.dst_port)));
            hits[k]    = lane_en && key.is_ipv4 && addr_ok && port_ok;
            actions[k] = rules_reg[k].action;
        end
    end

endmodule

FILE: verif/first_match_packet_acl_test.sv
// Testbench: first-match packet ACL checked against a cycle-free rule-table predictor.
`timescale 1ns / 1ps

module first_match_packet_acl_test;
    import fmacl_pkg::*;

    localparam int   SLOTS          = 16;
    localparam int   DRAIN_CYCLES   = 8;
    localparam int   STALL_LIMIT    = 4000;
    localparam int   PHASE_BEATS    = 135;
    localparam logic POLICY_ALLOW   = 1'b0;
    localparam logic POLICY_DENY    = 1'b1;
    localparam logic VERDICT_ACCEPT = 1'b0;
    localparam logic VERDICT_DROP   = 1'b1;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    typedef struct packed {
        logic        mode;
        logic [3:0]  rule_index;
        logic        is_ipv4;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] src_mask;
        logic [31:0] dst_mask;
        logic [7:0]  ip_protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        rule_verdict;
    } acl_beat_t;

    typedef struct packed {
        logic       result_kind;
        logic       matched;
        logic       verdict;
        logic [3:0] hit_index;
    } acl_outcome_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    fmacl_req_if req_ch ();
    fmacl_rsp_if rsp_ch ();

    first_match_packet_acl #(.RULE_SLOTS(SLOTS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    rule_t        acl_table  [SLOTS];
    rule_t        plan_table [SLOTS];
    logic [4:0]   live_count  = 5'd0;
    logic         live_policy = POLICY_ALLOW;
    acl_beat_t    beats_to_send [$];
    acl_outcome_t outcomes_due  [$];
    int           queued_beats   = 0;
    int           accepted_beats = 0;
    int           faults         = 0;
    int           quiet_cycles   = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    logic         req_took       = 1'b0;

    function automatic rule_t rule_of(acl_beat_t b);
        rule_t r;
        r.src_prefix = b.src_addr;
        r.src_mask   = b.src_mask;
        r.dst_prefix = b.dst_addr;
        r.dst_mask   = b.dst_mask;
        r.protocol   = b.ip_protocol;
        r.src_port   = b.src_port;
        r.dst_port   = b.dst_port;
        r.action     = b.rule_verdict;
        return r;
    endfunction

    function automatic logic rule_hits(rule_t r, acl_beat_t b);
        if ((r.src_prefix & r.src_mask) != (b.src_addr & r.src_mask))
            return 1'b0;
        if ((r.dst_prefix & r.dst_mask) != (b.dst_addr & r.dst_mask))
            return 1'b0;
        if (r.protocol != b.ip_protocol)
            return 1'b0;
        if (b.ip_protocol == PROTO_TCP || b.ip_protocol == PROTO_UDP)
            return (r.src_port == 16'd0 || r.src_port == b.src_port)
                && (r.dst_port == 16'd0 || r.dst_port == b.dst_port);
        return 1'b1;
    endfunction

    function automatic acl_outcome_t classify_or_store(acl_beat_t b);
        acl_outcome_t o;
        int n;
        o.result_kind = KIND_ACK;
        o.matched     = 1'b0;
        o.verdict     = 1'b0;
        o.hit_index   = 4'd0;
        if (b.mode == MODE_WRITE) begin
            acl_table[b.rule_index] = rule_of(b);
            return o;
        end
        o.result_kind = KIND_CLASSIFY;
        o.verdict     = (live_policy == POLICY_DENY) ? VERDICT_ACCEPT : VERDICT_DROP;
        n = (live_count > SLOTS) ? SLOTS : int'(live_count);
        if (b.is_ipv4) begin
            for (int k = 0; k < n; k++) begin
                if (rule_hits(acl_table[k], b)) begin
                    o.matched   = 1'b1;
                    o.verdict   = acl_table[k].action;
                    o.hit_index = 4'(k);
                    return o;
                end
            end
        end
        return o;
    endfunction

    task automatic log_fault(string what, acl_outcome_t want, acl_outcome_t got);
        faults++;
        if (faults <= 10) begin
            $display("mismatch (%s): expected kind=%0d matched=%0d verdict=%0d hit=%0d",
                     what, want.result_kind, want.matched, want.verdict, want.hit_index);
            $display("    got kind=%0d matched=%0d verdict=%0d hit=%0d",
                     got.result_kind, got.matched, got.verdict, got.hit_index);
        end
    endtask

    function automatic void queue_beat(acl_beat_t b);
        if (b.mode == MODE_WRITE)
            plan_table[b.rule_index] = rule_of(b);
        beats_to_send.push_back(b);
        queued_beats++;
    endfunction

    function automatic acl_beat_t noise_beat();
        acl_beat_t b;
        b.mode         = 1'($urandom);
        b.rule_index   = 4'($urandom);
        b.is_ipv4      = 1'($urandom);
        b.src_addr     = $urandom;
        b.dst_addr     = $urandom;
        b.src_mask     = $urandom;
        b.dst_mask     = $urandom;
        b.ip_protocol  = 8'($urandom);
        b.src_port     = 16'($urandom);
        b.dst_port     = 16'($urandom);
        b.rule_verdict = 1'($urandom);
        return b;
    endfunction

    function automatic acl_beat_t rule_beat(logic [3:0] slot, logic [31:0] sa, logic [31:0] sm,
                                            logic [31:0] da, logic [31:0] dm, logic [7:0] proto,
                                            logic [15:0] sp, logic [15:0] dp, logic act);
        acl_beat_t b;
        b = noise_beat();
        b.mode         = MODE_WRITE;
        b.rule_index   = slot;
        b.src_addr     = sa;
        b.src_mask     = sm;
        b.dst_addr     = da;
        b.dst_mask     = dm;
        b.ip_protocol  = proto;
        b.src_port     = sp;
        b.dst_port     = dp;
        b.rule_verdict = act;
        return b;
    endfunction

    function automatic acl_beat_t pkt_beat(logic ipv4, logic [31:0] sa, logic [31:0] da,
                                           logic [7:0] proto, logic [15:0] sp, logic [15:0] dp);
        acl_beat_t b;
        b = noise_beat();
        b.mode        = MODE_CLASSIFY;
        b.is_ipv4     = ipv4;
        b.src_addr    = sa;
        b.dst_addr    = da;
        b.ip_protocol = proto;
        b.src_port    = sp;
        b.dst_port    = dp;
        return b;
    endfunction

    function automatic logic [31:0] draw_mask();
        int len;
        case ($urandom_range(4, 0))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            4: return $urandom;
            default:
            begin
                len = $urandom_range(31, 1);
                return 32'hFFFF_FFFF << (32 - len);
            end
        endcase
    endfunction

    function automatic acl_beat_t random_rule(logic [3:0] slot);
        logic [7:0] proto;
        case ($urandom_range(4, 0))
            0, 1: proto = PROTO_TCP;
            2:    proto = PROTO_UDP;
            default: proto = 8'($urandom);
        endcase
        return rule_beat(slot, $urandom, draw_mask(), $urandom, draw_mask(), proto,
                         $urandom_range(1, 0) ? 16'd0 : 16'($urandom),
                         $urandom_range(1, 0) ? 16'd0 : 16'($urandom),
                         1'($urandom));
    endfunction

    // Build a packet that lands inside the given rule, then optionally nudge one field.
    function automatic acl_beat_t aimed_packet(rule_t r);
        acl_beat_t b;
        b = pkt_beat(1'b1,
                     (r.src_prefix & r.src_mask) | ($urandom & ~r.src_mask),
                     (r.dst_prefix & r.dst_mask) | ($urandom & ~r.dst_mask),
                     r.protocol,
                     (r.src_port != 16'd0) ? r.src_port : 16'($urandom),
                     (r.dst_port != 16'd0) ? r.dst_port : 16'($urandom));
        if ($urandom_range(4, 0) == 0) begin
            case ($urandom_range(4, 0))
                0: b.src_addr    ^= 32'd1 << $urandom_range(31, 0);
                1: b.dst_addr    ^= 32'd1 << $urandom_range(31, 0);
                2: b.ip_protocol ^= 8'd1 << $urandom_range(7, 0);
                3: b.src_port    ^= 16'd1 << $urandom_range(15, 0);
                default: b.dst_port ^= 16'd1 << $urandom_range(15, 0);
            endcase
        end
        return b;
    endfunction

    task automatic queue_random(int n, int span);
        acl_beat_t b;
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99, 0);
            if (pick < 25) begin
                b = random_rule(4'($urandom));
            end
            else if (pick < 90) begin
                b = aimed_packet(plan_table[$urandom_range(span - 1, 0)]);
                if (pick >= 80)
                    b.is_ipv4 = 1'b0;
            end
            else begin
                b = noise_beat();
                b.mode = MODE_CLASSIFY;
            end
            queue_beat(b);
        end
    endtask

    task automatic program_acl(logic [4:0] count, logic policy);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RULE_COUNT;
        cfg_data  <= CFG_W'(count);
        @(negedge clk);
        cfg_index <= REG_DEFAULT_POLICY;
        cfg_data  <= CFG_W'(policy);
        @(negedge clk);
        cfg_we    <= 1'b0;
        live_count  = count;
        live_policy = policy;
    endtask

    task automatic settle();
        while (accepted_beats != queued_beats || outcomes_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Driver: hold a beat until taken, otherwise advance or idle.
    always @(negedge clk) begin
        acl_beat_t nxt;
        logic give;
        if (!rst_n) begin
            req_ch.valid        <= 1'b0;
            req_ch.mode         <= MODE_WRITE;
            req_ch.rule_index   <= 4'd0;
            req_ch.is_ipv4      <= 1'b0;
            req_ch.src_addr     <= 32'd0;
            req_ch.dst_addr     <= 32'd0;
            req_ch.src_mask     <= 32'd0;
            req_ch.dst_mask     <= 32'd0;
            req_ch.ip_protocol  <= 8'd0;
            req_ch.src_port     <= 16'd0;
            req_ch.dst_port     <= 16'd0;
            req_ch.rule_verdict <= 1'b0;
        end
        else if (!(req_ch.valid && !req_took)) begin
            give = (beats_to_send.size() != 0) && ($urandom_range(99, 0) >= send_idle_pct);
            if (give) begin
                nxt = beats_to_send.pop_front();
                req_ch.mode         <= nxt.mode;
                req_ch.rule_index   <= nxt.rule_index;
                req_ch.is_ipv4      <= nxt.is_ipv4;
                req_ch.src_addr     <= nxt.src_addr;
                req_ch.dst_addr     <= nxt.dst_addr;
                req_ch.src_mask     <= nxt.src_mask;
                req_ch.dst_mask     <= nxt.dst_mask;
                req_ch.ip_protocol  <= nxt.ip_protocol;
                req_ch.src_port     <= nxt.src_port;
                req_ch.dst_port     <= nxt.dst_port;
                req_ch.rule_verdict <= nxt.rule_verdict;
            end
            req_ch.valid <= give;
        end
        rsp_ch.ready <= rst_n && ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Monitor: check result beats, predict from request beats, watch for a hang.
    always @(posedge clk) begin
        acl_beat_t    seen;
        acl_outcome_t got;
        acl_outcome_t want;
        logic         moved;
        moved    = 1'b0;
        req_took = rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            moved           = 1'b1;
            got.result_kind = rsp_ch.result_kind;
            got.matched     = rsp_ch.matched;
            got.verdict     = rsp_ch.verdict;
            got.hit_index   = rsp_ch.hit_index;
            if (outcomes_due.size() == 0) begin
                log_fault("result with nothing outstanding", got, got);
            end
            else begin
                want = outcomes_due.pop_front();
                if (got.result_kind !== want.result_kind || got.matched !== want.matched
                    || got.verdict !== want.verdict || got.hit_index !== want.hit_index)
                    log_fault("field", want, got);
            end
        end
        if (req_took) begin
            moved             = 1'b1;
            seen.mode         = req_ch.mode;
            seen.rule_index   = req_ch.rule_index;
            seen.is_ipv4      = req_ch.is_ipv4;
            seen.src_addr     = req_ch.src_addr;
            seen.dst_addr     = req_ch.dst_addr;
            seen.src_mask     = req_ch.src_mask;
            seen.dst_mask     = req_ch.dst_mask;
            seen.ip_protocol  = req_ch.ip_protocol;
            seen.src_port     = req_ch.src_port;
            seen.dst_port     = req_ch.dst_port;
            seen.rule_verdict = req_ch.rule_verdict;
            outcomes_due.push_back(classify_or_store(seen));
            accepted_beats++;
        end
        if (moved || !rst_n) begin
            quiet_cycles = 0;
        end
        else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        logic [4:0] phase_count  [7];
        logic       phase_policy [7];
        int span;
        phase_count  = '{5'd16, 5'd31, 5'd1, 5'd8, 5'd0, 5'd16, 5'd17};
        phase_policy = '{POLICY_ALLOW, POLICY_DENY, POLICY_ALLOW, POLICY_DENY,
                         POLICY_DENY, POLICY_ALLOW, POLICY_DENY};
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_RULE_COUNT;
        cfg_data            = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Empty table, allow-list: everything dropped. Then load the first rules.
        program_acl(5'd0, POLICY_ALLOW);
        queue_beat(pkt_beat(1'b1, 32'h0A01_0203, 32'hC0A8_014D, PROTO_TCP, 16'd1000, 16'd80));
        queue_beat(rule_beat(4'd0, 32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0100, 32'hFFFF_FF00,
                             PROTO_TCP, 16'd0, 16'd80, VERDICT_ACCEPT));
        queue_beat(rule_beat(4'd1, 32'h0, 32'h0, 32'h0, 32'h0,
                             PROTO_UDP, 16'd53, 16'd0, VERDICT_DROP));
        queue_beat(rule_beat(4'd2, 32'h0, 32'h0, 32'h0, 32'h0,
                             PROTO_ICMP, 16'd1234, 16'd5678, VERDICT_DROP));
        queue_beat(rule_beat(4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                             8'd255, 16'hFFFF, 16'hFFFF, VERDICT_ACCEPT));
        queue_beat(rule_beat(4'd4, 32'h1234_5678, 32'h0, 32'h9ABC_DEF0, 32'h0,
                             8'd0, 16'd0, 16'd0, VERDICT_ACCEPT));
        settle();

        // Deny-list over five rules: hits, misses, ports ignored off TCP/UDP, non-IPv4, a slot-0 rewrite.
        program_acl(5'd5, POLICY_DENY);
        queue_beat(pkt_beat(1'b1, 32'h0A01_0203, 32'hC0A8_014D, PROTO_TCP, 16'd1000, 16'd80));
        queue_beat(pkt_beat(1'b1, 32'h0A01_0203, 32'hC0A8_014D, PROTO_TCP, 16'd1000, 16'd81));
        queue_beat(pkt_beat(1'b0, 32'h0A01_0203, 32'hC0A8_014D, PROTO_TCP, 16'd1000, 16'd80));
        queue_beat(pkt_beat(1'b1, 32'hFFFF_FFFF, 32'h0, PROTO_UDP, 16'd53, 16'hFFFF));
        queue_beat(pkt_beat(1'b1, 32'h0, 32'h0, PROTO_UDP, 16'd54, 16'd0));
        queue_beat(pkt_beat(1'b1, 32'h0102_0304, 32'h0506_0708, PROTO_ICMP, 16'd0, 16'd0));
        queue_beat(pkt_beat(1'b1, 32'hFFFF_FFFF, 32'h0, 8'd255, 16'd0, 16'd0));
        queue_beat(pkt_beat(1'b1, 32'hFFFF_FFFE, 32'h0, 8'd255, 16'hFFFF, 16'hFFFF));
        queue_beat(pkt_beat(1'b1, 32'h0, 32'hFFFF_FFFF, 8'd0, 16'hFFFF, 16'hFFFF));
        queue_beat(rule_beat(4'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                             PROTO_TCP, 16'd0, 16'd0, VERDICT_DROP));
        queue_beat(pkt_beat(1'b1, 32'h0A01_0203, 32'hC0A8_014D, PROTO_TCP, 16'd1000, 16'd81));
        settle();

        // Seven random phases; the first fills the rest of the table before any read past slot four.
        for (int p = 0; p < 7; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            program_acl(phase_count[p], phase_policy[p]);
            if (p == 0) begin
                for (int s = 5; s < SLOTS; s++)
                    queue_beat(random_rule(4'(s)));
            end
            span = (phase_count[p] > SLOTS) ? SLOTS : int'(phase_count[p]);
            if (span == 0)
                span = SLOTS;
            queue_random(PHASE_BEATS, span);
            settle();
        end

        if (faults == 0 && outcomes_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/fmacl_pkg.sv
rtl/core/fmacl_if.sv
rtl/core/fmacl_rule_table.sv
rtl/core/first_match_packet_acl.sv
verif/first_match_packet_acl_test.sv
